[src/dmc_pkg.sv]
// Shared types and constants of the maze carver: state codes, opcodes, direction codes,
// register indexes and the command structs that pass between the memory blocks.
// No dependencies.
package dmc_pkg;

  parameter int DMC_MAX_ROWS    = 64;
  parameter int DMC_MAX_COLS    = 64;
  parameter int DMC_STACK_DEPTH = 4096;

  parameter int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  localparam logic [6:0] GRID_ROWS_RESET = 7'd10;
  localparam logic [6:0] GRID_COLS_RESET = 7'd11;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WIPE,
    ST_POP,
    ST_ROWS,
    ST_EVAL,
    ST_SHUF,
    ST_PUSH,
    ST_READ,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic rd;
    logic carve;
    logic wipe;
  } wall_cmd_t;

  typedef struct packed {
    logic init;
    logic pop;
    logic push;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  typedef struct packed {
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       carved;
    logic [2:0] pushed_count;
    logic       walk_done;
    logic       stack_overflow;
    logic       cell_open;
  } res_t;

endpackage

[src/dfs_maze_carver.sv]
// Top level of the depth-first maze carver: sequencer, configuration registers and
// output register around the wall map, the cell stack and the neighbourhood evaluator.
// Depends on dmc_pkg, dmc_wall_map, dmc_stack and dmc_eval.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  op, swap_digits, read_row, read_col
//   out      output     out_valid_o/out_stall_i cell_row .. cell_open
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A step reads the five rows around the cell one per cycle from the single-port wall map
// and, when the cell is opened, tries the four directions one per cycle for pushes into
// the single-port stack; a step on an empty stack does neither.
// A start runs the fill sweep of the wall map, one row per cycle.
// After reset the same sweep runs, and the input stays stalled until it is over.
// A finished result waits in the output register; the next item is taken meanwhile.
module dfs_maze_carver #(
  parameter int MAX_ROWS    = dmc_pkg::DMC_MAX_ROWS,
  parameter int MAX_COLS    = dmc_pkg::DMC_MAX_COLS,
  parameter int STACK_DEPTH = dmc_pkg::DMC_STACK_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [19:0]                   swap_digits_i,
  input  logic [5:0]                    read_row_i,
  input  logic [5:0]                    read_col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    cell_row_o,
  output logic [5:0]                    cell_col_o,
  output logic                          carved_o,
  output logic [2:0]                    pushed_count_o,
  output logic                          walk_done_o,
  output logic                          stack_overflow_o,
  output logic                          cell_open_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [6:0]                    cfg_data_i
);
  import dmc_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int RU_W  = $clog2(MAX_ROWS + 1);
  localparam int CU_W  = $clog2(MAX_COLS + 1);
  localparam int SC_W  = $clog2(STACK_DEPTH + 1);

  function automatic logic [3:0][1:0] shuffle5(input logic [3:0][1:0] ord,
                                               input logic [9:0]      dg);
    logic [3:0][1:0] o;
    logic [1:0]      s;
    logic [1:0]      t;
    o = ord;
    for (int k = 0; k < 5; k++) begin
      case (dg[2*k +: 2])
        2'd0: begin
          s = 2'd1;
        end
        2'd1: begin
          s = 2'd2;
        end
        default: begin
          s = 2'd3;
        end
      endcase
      t    = o[s];
      o[s] = o[0];
      o[0] = t;
    end
    return o;
  endfunction

  state_e          state_q, state_d;
  logic [6:0]      grid_rows_q, grid_cols_q;
  logic [3:0][1:0] order_q, order_d;
  logic [2:0]      rk_q, rk_d;
  logic [1:0]      pk_q, pk_d;
  logic            out_valid_q;
  res_t            out_q;

  logic [19:0]      digits_q, digits_d;
  logic [5:0]       rrow_q, rrow_d, rcol_q, rcol_d;
  logic [ROW_W-1:0] cur_row_q, cur_row_d;
  logic [COL_W-1:0] cur_col_q, cur_col_d;
  logic [4:0][4:0]  win_q, win_d;
  logic [3:0]       nok_q, nok_d;
  res_t             res_q, res_d;
  res_t             load_res;

  logic [RU_W-1:0] rows_used;
  logic [CU_W-1:0] cols_used;

  wall_cmd_t           wall_cmd;
  logic [ROW_W-1:0]    wall_rd_row;
  logic [MAX_COLS-1:0] wall_rd_data;
  logic                wall_clearing;

  stk_cmd_t         stk_cmd;
  logic [ROW_W-1:0] push_row;
  logic [COL_W-1:0] push_col;
  logic [ROW_W-1:0] pop_row;
  logic [COL_W-1:0] pop_col;
  logic [SC_W-1:0]  stk_count;
  stk_stat_t        stk_stat;

  logic            carve_ok;
  logic [3:0]      nok;
  logic            in_xfer;
  logic            out_load;
  logic [MAX_COLS+3:0] pad_row;
  logic [MAX_COLS-1:0] rd_shift;
  logic [1:0]      push_dir;

  dmc_wall_map #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_wall (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (wall_cmd),
    .rd_row_i   (wall_rd_row),
    .wr_row_i   (cur_row_q),
    .wr_col_i   (cur_col_q),
    .rd_data_o  (wall_rd_data),
    .clearing_o (wall_clearing)
  );

  dmc_stack #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .push_row_i (push_row),
    .push_col_i (push_col),
    .pop_row_o  (pop_row),
    .pop_col_o  (pop_col),
    .count_o    (stk_count),
    .stat_o     (stk_stat)
  );

  dmc_eval #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_eval (
    .win_i       (win_q),
    .cur_row_i   (cur_row_q),
    .cur_col_i   (cur_col_q),
    .rows_used_i (rows_used),
    .cols_used_i (cols_used),
    .carve_ok_o  (carve_ok),
    .nok_o       (nok)
  );

  always_comb begin
    if (grid_rows_q == '0) begin
      rows_used = RU_W'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_used = RU_W'(MAX_ROWS);
    end else begin
      rows_used = RU_W'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      cols_used = CU_W'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_used = CU_W'(MAX_COLS);
    end else begin
      cols_used = CU_W'(grid_cols_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign pad_row     = {2'b11, wall_rd_data, 2'b11} >> cur_col_q;
  assign rd_shift    = wall_rd_data >> rcol_q;
  assign push_dir    = order_q[pk_q];

  always_comb begin
    state_d     = state_q;
    order_d     = order_q;
    rk_d        = rk_q;
    pk_d        = pk_q;
    digits_d    = digits_q;
    rrow_d      = rrow_q;
    rcol_d      = rcol_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    win_d       = win_q;
    nok_d       = nok_q;
    res_d       = res_q;
    wall_cmd    = '0;
    wall_rd_row = ROW_W'(int'(cur_row_q) + int'(rk_q) - 2);
    stk_cmd     = '0;
    push_row    = cur_row_q;
    push_col    = cur_col_q;

    case (push_dir)
      DIR_DOWN: begin
        push_row = ROW_W'(int'(cur_row_q) + 1);
      end
      DIR_UP: begin
        push_row = ROW_W'(int'(cur_row_q) - 1);
      end
      DIR_RIGHT: begin
        push_col = COL_W'(int'(cur_col_q) + 1);
      end
      default: begin
        push_col = COL_W'(int'(cur_col_q) - 1);
      end
    endcase

    case (state_q)
      ST_INIT: begin
        if (!wall_clearing) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          digits_d = swap_digits_i;
          rrow_d   = read_row_i;
          rcol_d   = read_col_i;
          res_d    = '0;
          case (op_i)
            OP_START: begin
              stk_cmd.init  = 1'b1;
              wall_cmd.wipe = 1'b1;
              order_d       = {DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN};
              state_d       = ST_WIPE;
            end
            OP_STEP: begin
              if (stk_stat.empty) begin
                state_d = ST_FIN;
              end else begin
                stk_cmd.pop = 1'b1;
                state_d     = ST_POP;
              end
            end
            OP_READ: begin
              wall_cmd.rd    = 1'b1;
              wall_rd_row    = ROW_W'(read_row_i);
              res_d.cell_row = read_row_i;
              res_d.cell_col = read_col_i;
              state_d        = ST_READ;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_WIPE: begin
        if (!wall_clearing) begin
          state_d = ST_FIN;
        end
      end
      ST_POP: begin
        cur_row_d      = pop_row;
        cur_col_d      = pop_col;
        res_d.cell_row = 6'(pop_row);
        res_d.cell_col = 6'(pop_col);
        rk_d           = '0;
        state_d        = ST_ROWS;
      end
      ST_ROWS: begin
        wall_cmd.rd = (rk_q < 3'd5);
        for (int i = 0; i < 5; i++) begin
          if (32'(rk_q) == i + 1) begin
            win_d[i] = pad_row[4:0];
          end
        end
        rk_d = rk_q + 3'd1;
        if (rk_q == 3'd5) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        nok_d = nok;
        if (carve_ok) begin
          wall_cmd.carve = 1'b1;
          res_d.carved   = 1'b1;
          order_d        = shuffle5(order_q, digits_q[9:0]);
          state_d        = ST_SHUF;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SHUF: begin
        order_d = shuffle5(order_q, digits_q[19:10]);
        pk_d    = '0;
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (nok_q[push_dir]) begin
          if (stk_stat.full) begin
            res_d.stack_overflow = 1'b1;
          end else begin
            stk_cmd.push       = 1'b1;
            res_d.pushed_count = res_q.pushed_count + 3'd1;
          end
        end
        pk_d = pk_q + 2'd1;
        if (pk_q == 2'd3) begin
          state_d = ST_FIN;
        end
      end
      ST_READ: begin
        res_d.cell_open = (32'(rrow_q) < MAX_ROWS) && (32'(rcol_q) < MAX_COLS) &&
                          !rd_shift[0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    load_res           = res_q;
    load_res.walk_done = stk_stat.empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      order_q     <= {DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN};
      rk_q        <= '0;
      pk_q        <= '0;
      out_valid_q <= 1'b0;
      grid_rows_q <= GRID_ROWS_RESET;
      grid_cols_q <= GRID_COLS_RESET;
    end else begin
      state_q <= state_d;
      order_q <= order_d;
      rk_q    <= rk_d;
      pk_q    <= pk_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GRID_ROWS: begin
            grid_rows_q <= cfg_data_i;
          end
          REG_GRID_COLS: begin
            grid_cols_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q  <= digits_d;
    rrow_q    <= rrow_d;
    rcol_q    <= rcol_d;
    cur_row_q <= cur_row_d;
    cur_col_q <= cur_col_d;
    win_q     <= win_d;
    nok_q     <= nok_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= load_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_row_o       = out_q.cell_row;
  assign cell_col_o       = out_q.cell_col;
  assign carved_o         = out_q.carved;
  assign pushed_count_o   = out_q.pushed_count;
  assign walk_done_o      = out_q.walk_done;
  assign stack_overflow_o = out_q.stack_overflow;
  assign cell_open_o      = out_q.cell_open;

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cmd.push |-> !stk_stat.full)
    else $error("push issued onto a full stack");

  a_load_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the finish state");

  a_stall_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wall_clearing |-> in_stall_o)
    else $error("input taken during the wall fill sweep");

  a_skip_pushes_nothing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !carved_o |-> pushed_count_o == 3'd0 && !stack_overflow_o)
    else $error("skipped cell reports pushes");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> 32'(stk_count) <= STACK_DEPTH)
    else $error("stack count beyond depth");

endmodule

[src/dmc_wall_map.sv]
// Row-wide wall map memory: one word per row, one bit per column, 1 for wall.
// Holds the fill sweep that walls the whole grid after reset and on request.
// Depends on dmc_pkg.
module dmc_wall_map #(
  parameter int MAX_ROWS = dmc_pkg::DMC_MAX_ROWS,
  parameter int MAX_COLS = dmc_pkg::DMC_MAX_COLS,
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int COL_W = $clog2(MAX_COLS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmc_pkg::wall_cmd_t  cmd_i,
  input  logic [ROW_W-1:0]    rd_row_i,
  input  logic [ROW_W-1:0]    wr_row_i,
  input  logic [COL_W-1:0]    wr_col_i,
  output logic [MAX_COLS-1:0] rd_data_o,
  output logic                clearing_o
);
  import dmc_pkg::*;

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_q;
  logic                clearing_q;
  logic [ROW_W-1:0]    clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (cmd_i.wipe) begin
      clearing_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clearing_q) begin
      if (32'(clr_row_q) == MAX_ROWS - 1) begin
        clearing_q <= 1'b0;
      end else begin
        clr_row_q <= clr_row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_row_q] <= '1;
    end else if (cmd_i.carve) begin
      mem_q[wr_row_i][wr_col_i] <= 1'b0;
    end
    if (cmd_i.rd) begin
      if (32'(rd_row_i) < MAX_ROWS) begin
        rd_q <= mem_q[rd_row_i];
      end else begin
        rd_q <= '1;
      end
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clearing_q;

endmodule

[src/dmc_stack.sv]
// Cell stack of the walk: a single-port memory of row and column pairs and its fill count.
// Pop reads the top entry into a register; a push onto a full stack is dropped.
// Depends on dmc_pkg.
module dmc_stack #(
  parameter int MAX_ROWS    = dmc_pkg::DMC_MAX_ROWS,
  parameter int MAX_COLS    = dmc_pkg::DMC_MAX_COLS,
  parameter int STACK_DEPTH = dmc_pkg::DMC_STACK_DEPTH,
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int COL_W = $clog2(MAX_COLS),
  localparam int SI_W  = $clog2(STACK_DEPTH),
  localparam int SC_W  = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmc_pkg::stk_cmd_t  cmd_i,
  input  logic [ROW_W-1:0]   push_row_i,
  input  logic [COL_W-1:0]   push_col_i,
  output logic [ROW_W-1:0]   pop_row_o,
  output logic [COL_W-1:0]   pop_col_o,
  output logic [SC_W-1:0]    count_o,
  output dmc_pkg::stk_stat_t stat_o
);
  import dmc_pkg::*;

  logic [ROW_W+COL_W-1:0] mem_q [STACK_DEPTH];
  logic [ROW_W+COL_W-1:0] rd_q;
  logic [SC_W-1:0]        count_q;
  logic                   full;

  assign full = (32'(count_q) >= STACK_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.init) begin
      count_q <= SC_W'(1);
    end else if (cmd_i.pop) begin
      count_q <= count_q - 1'b1;
    end else if (cmd_i.push && !full) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      mem_q[0] <= '0;
    end else if (cmd_i.push && !full) begin
      mem_q[count_q[SI_W-1:0]] <= {push_row_i, push_col_i};
    end
    if (cmd_i.pop) begin
      rd_q <= mem_q[SI_W'(count_q - 1'b1)];
    end
  end

  assign pop_row_o    = rd_q[ROW_W+COL_W-1:COL_W];
  assign pop_col_o    = rd_q[COL_W-1:0];
  assign count_o      = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = full;

endmodule

[src/dmc_eval.sv]
// Neighbourhood evaluation of a popped cell from a five by five window of wall bits.
// Decides whether the cell is opened and which of its four neighbours may be stacked.
// Depends on dmc_pkg.
module dmc_eval #(
  parameter int MAX_ROWS = dmc_pkg::DMC_MAX_ROWS,
  parameter int MAX_COLS = dmc_pkg::DMC_MAX_COLS,
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int COL_W = $clog2(MAX_COLS),
  localparam int RU_W  = $clog2(MAX_ROWS + 1),
  localparam int CU_W  = $clog2(MAX_COLS + 1)
) (
  input  logic [4:0][4:0]  win_i,
  input  logic [ROW_W-1:0] cur_row_i,
  input  logic [COL_W-1:0] cur_col_i,
  input  logic [RU_W-1:0]  rows_used_i,
  input  logic [CU_W-1:0]  cols_used_i,
  output logic             carve_ok_o,
  output logic [3:0]       nok_o
);
  import dmc_pkg::*;

  logic [4:0]      rin;
  logic [4:0]      cin;
  logic [4:0][4:0] opn;
  logic [4:0][4:0] wal;
  logic [2:0]      n0;

  // Row i of the window is row cur-2+i; bit j of a row is column cur-2+j.
  always_comb begin
    int rv;
    int cv;
    for (int i = 0; i < 5; i++) begin
      rv = int'(cur_row_i) + i - 2;
      cv = int'(cur_col_i) + i - 2;
      rin[i] = (rv >= 0) && (rv < int'(rows_used_i));
      cin[i] = (cv >= 0) && (cv < int'(cols_used_i));
    end
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        opn[i][j] = rin[i] & cin[j] & ~win_i[i][j];
        wal[i][j] = rin[i] & cin[j] & win_i[i][j];
      end
    end
    n0 = {2'b0, opn[1][2]} + {2'b0, opn[3][2]} + {2'b0, opn[2][3]} + {2'b0, opn[2][1]};
    carve_ok_o = rin[2] & cin[2] & (n0 <= 3'd1);
    // The centre counts as open for every neighbour, so one more open cell is too many.
    nok_o[DIR_DOWN]  = wal[3][2] & ~(opn[4][2] | opn[3][3] | opn[3][1]);
    nok_o[DIR_UP]    = wal[1][2] & ~(opn[0][2] | opn[1][3] | opn[1][1]);
    nok_o[DIR_RIGHT] = wal[2][3] & ~(opn[2][4] | opn[1][3] | opn[3][3]);
    nok_o[DIR_LEFT]  = wal[2][1] & ~(opn[2][0] | opn[1][1] | opn[3][1]);
  end

endmodule

[tb/sv/tb_dmc_checker.sv]
`timescale 1ns / 1ps
// Checker for the depth-first maze carver: watches the input, output and register channels,
// predicts each result from its own copy of the grid, stack and direction order, and compares.
// Depends on dmc_pkg for the opcodes, direction codes, register indexes and the result struct.
module tb_dmc_checker
  import dmc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           op_i,
  input  logic [19:0]          swap_digits_i,
  input  logic [5:0]           read_row_i,
  input  logic [5:0]           read_col_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [5:0]           cell_row_i,
  input  logic [5:0]           cell_col_i,
  input  logic                 carved_i,
  input  logic [2:0]           pushed_count_i,
  input  logic                 walk_done_i,
  input  logic                 stack_overflow_i,
  input  logic                 cell_open_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  output int                   errors_o,
  output int                   backlog_o,
  output int                   depth_o
);

  bit          wall_q [DMC_MAX_ROWS*DMC_MAX_COLS];
  logic [11:0] stack_q [DMC_STACK_DEPTH];
  int          depth_q;
  dir_e        order_q [4];
  logic [6:0]  rows_q;
  logic [6:0]  cols_q;
  res_t        due_results [$];
  int          errors_q;

  function automatic void fill_walls();
    foreach (wall_q[i]) wall_q[i] = 1'b1;
  endfunction

  function automatic void restore_order();
    order_q[0] = DIR_DOWN;
    order_q[1] = DIR_UP;
    order_q[2] = DIR_RIGHT;
    order_q[3] = DIR_LEFT;
  endfunction

  function automatic int rows_in_use();
    if (rows_q == 0) return 1;
    if (rows_q > DMC_MAX_ROWS) return DMC_MAX_ROWS;
    return int'(rows_q);
  endfunction

  function automatic int cols_in_use();
    if (cols_q == 0) return 1;
    if (cols_q > DMC_MAX_COLS) return DMC_MAX_COLS;
    return int'(cols_q);
  endfunction

  function automatic int drow(dir_e d);
    case (d)
      DIR_DOWN: return 1;
      DIR_UP:   return -1;
      default:  return 0;
    endcase
  endfunction

  function automatic int dcol(dir_e d);
    case (d)
      DIR_RIGHT: return 1;
      DIR_LEFT:  return -1;
      default:   return 0;
    endcase
  endfunction

  // Cells outside the area in use count as neither wall nor passage.
  function automatic bit holds(int r, int c, bit want_wall);
    if (r < 0 || r >= rows_in_use() || c < 0 || c >= cols_in_use()) return 1'b0;
    return wall_q[r*DMC_MAX_COLS + c] == want_wall;
  endfunction

  function automatic int open_around(int r, int c);
    int n = 0;
    for (int k = 0; k < 4; k++) begin
      n += holds(r + drow(dir_e'(k)), c + dcol(dir_e'(k)), 1'b0);
    end
    return n;
  endfunction

  function automatic res_t walk_item(logic [1:0] op, logic [19:0] digits,
                                     logic [5:0] rr, logic [5:0] rc);
    res_t        res;
    logic [11:0] code;
    logic [1:0]  dig;
    int          r, c, nr, nc, slot;
    dir_e        d, t;
    res = '0;
    case (op)
      OP_START: begin
        fill_walls();
        restore_order();
        stack_q[0] = '0;
        depth_q = 1;
      end
      OP_STEP: if (depth_q > 0) begin
        depth_q--;
        code = stack_q[depth_q];
        r = code / DMC_MAX_COLS;
        c = code % DMC_MAX_COLS;
        res.cell_row = r[5:0];
        res.cell_col = c[5:0];
        if (r < rows_in_use() && c < cols_in_use() && open_around(r, c) <= 1) begin
          wall_q[r*DMC_MAX_COLS + c] = 1'b0;
          res.carved = 1'b1;
          for (int k = 0; k < 10; k++) begin
            dig = digits[2*k +: 2];
            slot = (dig > 2'd2) ? 3 : 1 + int'(dig);
            t = order_q[slot];
            order_q[slot] = order_q[0];
            order_q[0] = t;
          end
          for (int k = 0; k < 4; k++) begin
            d = order_q[k];
            nr = r + drow(d);
            nc = c + dcol(d);
            if (holds(nr, nc, 1'b1) && open_around(nr, nc) <= 1) begin
              if (depth_q >= DMC_STACK_DEPTH) begin
                res.stack_overflow = 1'b1;
              end else begin
                stack_q[depth_q] = 12'(nr*DMC_MAX_COLS + nc);
                depth_q++;
                res.pushed_count = res.pushed_count + 3'd1;
              end
            end
          end
        end
      end
      OP_READ: begin
        res.cell_row = rr;
        res.cell_col = rc;
        res.cell_open = ~wall_q[rr*DMC_MAX_COLS + rc];
      end
      default: ;
    endcase
    res.walk_done = (depth_q == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      errors_q++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      fill_walls();
      restore_order();
      depth_q = 0;
      rows_q = GRID_ROWS_RESET;
      cols_q = GRID_COLS_RESET;
      due_results.delete();
      errors_q = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, actual row %0d col %0d carved %0d",
                   $time, cell_row_i, cell_col_i, carved_i);
          errors_q++;
        end else begin
          want = due_results.pop_front();
          check_field("cell_row", 8'(want.cell_row), 8'(cell_row_i));
          check_field("cell_col", 8'(want.cell_col), 8'(cell_col_i));
          check_field("carved", 8'(want.carved), 8'(carved_i));
          check_field("pushed_count", 8'(want.pushed_count), 8'(pushed_count_i));
          check_field("walk_done", 8'(want.walk_done), 8'(walk_done_i));
          check_field("stack_overflow", 8'(want.stack_overflow), 8'(stack_overflow_i));
          check_field("cell_open", 8'(want.cell_open), 8'(cell_open_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_GRID_ROWS) rows_q = cfg_data_i;
        else if (cfg_index_i == REG_GRID_COLS) cols_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(walk_item(op_i, swap_digits_i, read_row_i, read_col_i));
      end
    end
    errors_o <= errors_q;
    backlog_o <= due_results.size();
    depth_o <= depth_q;
  end

endmodule

[tb/sv/tb_dfs_maze_carver.sv]
`timescale 1ns / 1ps
// Top of the maze carver testbench: clock, reset, stimulus for the item and register channels,
// random stalls on the result channel and the verdict. Depends on dmc_pkg, dfs_maze_carver
// and tb_dmc_checker.
module tb_dfs_maze_carver;
  import dmc_pkg::*;

  localparam int ITEM_GOAL    = 1150;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [6:0]           REG_MAX   = 7'd127;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           op = OP_READ;
  logic [19:0]          swap_digits = '0;
  logic [5:0]           read_row = '0;
  logic [5:0]           read_col = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [5:0]           cell_row;
  logic [5:0]           cell_col;
  logic                 carved;
  logic [2:0]           pushed_count;
  logic                 walk_done;
  logic                 stack_overflow;
  logic                 cell_open;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0]           cfg_data = '0;

  int         err_count;
  int         backlog;
  int         walk_depth;
  int         cycles = 0;
  int         sent = 0;
  int         idle_pct = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;
  logic [6:0] rows_cfg = GRID_ROWS_RESET;
  logic [6:0] cols_cfg = GRID_COLS_RESET;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dfs_maze_carver uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op),
    .swap_digits_i   (swap_digits),
    .read_row_i      (read_row),
    .read_col_i      (read_col),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .cell_row_o      (cell_row),
    .cell_col_o      (cell_col),
    .carved_o        (carved),
    .pushed_count_o  (pushed_count),
    .walk_done_o     (walk_done),
    .stack_overflow_o(stack_overflow),
    .cell_open_o     (cell_open),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  tb_dmc_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .op_i            (op),
    .swap_digits_i   (swap_digits),
    .read_row_i      (read_row),
    .read_col_i      (read_col),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .cell_row_i      (cell_row),
    .cell_col_i      (cell_col),
    .carved_i        (carved),
    .pushed_count_i  (pushed_count),
    .walk_done_i     (walk_done),
    .stack_overflow_i(stack_overflow),
    .cell_open_i     (cell_open),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .errors_o        (err_count),
    .backlog_o       (backlog),
    .depth_o         (walk_depth)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet || idle_pct == 0) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Returns at the edge of the transfer with valid still high, so the next call must
  // follow in the same time step.
  task automatic send_item(input logic [1:0] op_v, input logic [19:0] digits,
                           input logic [5:0] row, input logic [5:0] col);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_v;
    swap_digits <= digits;
    read_row <= row;
    read_col <= col;
    do @(posedge clk); while (in_stall);
    if (op_v != OP_UNUSED) sent++;
    if (sent >= ITEM_GOAL - QUIET_TAIL) quiet = 1'b1;
  endtask

  task automatic rand_step();
    send_item(OP_STEP, 20'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic start_walk();
    send_item(OP_START, 20'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic read_cell(input logic [5:0] row, input logic [5:0] col);
    send_item(OP_READ, 20'($urandom), row, col);
  endtask

  task automatic read_in_area();
    int r_hi, c_hi;
    r_hi = (rows_cfg == 0) ? 0 : (rows_cfg > DMC_MAX_ROWS) ? DMC_MAX_ROWS - 1 : rows_cfg - 1;
    c_hi = (cols_cfg == 0) ? 0 : (cols_cfg > DMC_MAX_COLS) ? DMC_MAX_COLS - 1 : cols_cfg - 1;
    read_cell(6'($urandom_range(0, r_hi)), 6'($urandom_range(0, c_hi)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  task automatic write_grid(input logic [6:0] r, input logic [6:0] c, input bit spare);
    rows_cfg = r;
    cols_cfg = c;
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_GRID_COLS;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    if (spare) begin
      cfg_index <= REG_SPARE;
      cfg_data <= 7'($urandom_range(0, 127));
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic walk(input int cap, input bit may_shrink);
    int n, roll;
    n = 0;
    start_walk();
    while (n < cap && sent < ITEM_GOAL && (n < 2 || walk_depth != 0)) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        rand_step();
      end else if (roll < 88) begin
        read_in_area();
      end else if (roll < 91) begin
        read_cell(6'($urandom), 6'($urandom));
      end else if (roll < 93) begin
        send_item(OP_UNUSED, 20'($urandom), 6'($urandom), 6'($urandom));
      end else if (roll < 95) begin
        start_walk();
      end else if (roll < 97 && may_shrink) begin
        settle();
        write_grid(7'($urandom_range(0, rows_cfg)), 7'($urandom_range(0, cols_cfg)), 1'b0);
      end else begin
        rand_step();
      end
      n++;
    end
  endtask

  initial begin
    int         pick;
    int         big_left;
    bit         big;
    logic [6:0] r, c;
    big_left = 2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 30;
    read_cell(6'd0, 6'd0);
    send_item(OP_STEP, 20'h00000, 6'd0, 6'd0);
    send_item(OP_UNUSED, 20'hFFFFF, 6'd63, 6'd63);
    read_cell(6'd63, 6'd63);
    send_item(OP_START, 20'hFFFFF, 6'd63, 6'd63);
    send_item(OP_STEP, 20'h00000, 6'd0, 6'd0);
    send_item(OP_STEP, 20'hFFFFF, 6'd63, 6'd63);
    send_item(OP_STEP, 20'h55555, 6'd21, 6'd42);
    send_item(OP_STEP, 20'hAAAAA, 6'd42, 6'd21);
    read_cell(6'd0, 6'd0);
    read_cell(6'd1, 6'd0);
    send_item(OP_UNUSED, 20'h00000, 6'd0, 6'd0);
    start_walk();
    rand_step();
    settle();
    write_grid(7'd0, REG_MAX, 1'b1);
    start_walk();
    repeat (4) rand_step();
    read_cell(6'd0, 6'd3);
    // The grid shrinks under a live walk, so cells already stacked fall outside it.
    settle();
    write_grid(7'd1, 7'd1, 1'b0);
    repeat (3) rand_step();
    settle();
    write_grid(REG_MAX, 7'd0, 1'b0);
    start_walk();
    repeat (2) rand_step();

    while (sent < ITEM_GOAL) begin
      settle();
      pick = $urandom_range(0, 9);
      big = 1'b0;
      if (pick == 0 && big_left > 0) begin
        big_left--;
        big = 1'b1;
        r = $urandom_range(0, 1) ? REG_MAX : 7'd64;
        c = $urandom_range(0, 1) ? REG_MAX : 7'd64;
      end else if (pick == 1) begin
        r = 7'($urandom_range(0, 1));
        c = 7'($urandom_range(1, 20));
      end else if (pick == 2) begin
        r = 7'($urandom_range(1, 20));
        c = 7'($urandom_range(0, 1));
      end else begin
        r = 7'($urandom_range(2, 12));
        c = 7'($urandom_range(2, 12));
      end
      write_grid(r, c, $urandom_range(0, 5) == 0);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      walk(big ? 200 : 400, !big);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && backlog == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
